// File: hdl/sparse_brick_voxel_store_macros.svh
// ----------------------------------------------------------------------------
// sparse_brick_voxel_store_macros
// Assertion macros for the sparse brick voxel store; clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef SPARSE_BRICK_VOXEL_STORE_MACROS_SVH
`define SPARSE_BRICK_VOXEL_STORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SBVS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbvs implication check failed");

// expression holds at every edge out of reset
`define SBVS_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("sbvs invariant check failed");

`endif

// File: hdl/sbvs_pkg.sv
// ----------------------------------------------------------------------------
// sbvs_pkg
// Shared types and constants of the sparse brick voxel store.
// ----------------------------------------------------------------------------
`default_nettype none

package sbvs_pkg;

  localparam int MAX_MAP_BRICKS_DEF = 4096;
  localparam int POOL_BRICKS_DEF    = 256;
  localparam int VOXEL_BITS_DEF     = 8;

  localparam int BRICK_BITS   = 9;
  localparam int BRICK_VOXELS = 8 * 8 * 8;
  localparam int IDX_W        = 12;
  localparam int EXTENT_MAX   = 16;
  localparam int Q_DEPTH      = 2;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] REG_BRICKS_X = 2'd0;
  localparam logic [1:0] REG_BRICKS_Y = 2'd1;
  localparam logic [1:0] REG_BRICKS_Z = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    K_READ,
    K_WRITE,
    K_CLEAR,
    K_NOP,
    K_RANGE
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [IDX_W-1:0]        idx;
    logic [BRICK_BITS-1:0]   vox;
    logic [7:0]              value;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// File: hdl/sbvs_front.sv
// ----------------------------------------------------------------------------
// sbvs_front
// Extent registers, command accept, brick index and range classification.
// ----------------------------------------------------------------------------
`default_nettype none

module sbvs_front #(
  parameter int MAX_MAP_BRICKS = sbvs_pkg::MAX_MAP_BRICKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [4:0]           cfg_data,
  input  logic                 start,
  input  logic [1:0]           cmd,
  input  logic [6:0]           pos_x,
  input  logic [6:0]           pos_y,
  input  logic [6:0]           pos_z,
  input  logic [7:0]           write_value,
  input  sbvs_pkg::q_status_t  q_stat,
  input  logic                 init_busy,
  output logic                 busy,
  output logic                 push,
  output sbvs_pkg::item_t      item
);

  logic [4:0]  ex;
  logic [4:0]  ey;
  logic [4:0]  ez;
  logic [8:0]  exy;
  logic [4:0]  cfg_clamped;
  logic [3:0]  bx;
  logic [3:0]  by;
  logic [3:0]  bz;
  logic [13:0] idx_full;
  logic        out_of_range;

  function automatic logic [4:0] clamp_ext(input logic [4:0] v);
    return (v > 5'(sbvs_pkg::EXTENT_MAX)) ? 5'(sbvs_pkg::EXTENT_MAX) : v;
  endfunction

  assign cfg_clamped = clamp_ext(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      ex  <= 5'(sbvs_pkg::EXTENT_MAX);
      ey  <= 5'(sbvs_pkg::EXTENT_MAX);
      ez  <= 5'(sbvs_pkg::EXTENT_MAX);
      exy <= 9'(sbvs_pkg::EXTENT_MAX * sbvs_pkg::EXTENT_MAX);
    end else if (cfg_we) begin
      case (cfg_index)
        sbvs_pkg::REG_BRICKS_X: begin
          ex  <= cfg_clamped;
          exy <= 9'(10'(cfg_clamped) * 10'(ey));
        end
        sbvs_pkg::REG_BRICKS_Y: begin
          ey  <= cfg_clamped;
          exy <= 9'(10'(ex) * 10'(cfg_clamped));
        end
        sbvs_pkg::REG_BRICKS_Z: begin
          ez <= cfg_clamped;
        end
        default: ;
      endcase
    end
  end

  assign bx = pos_x[6:3];
  assign by = pos_y[6:3];
  assign bz = pos_z[6:3];

  assign idx_full = 14'(bx) + 14'(by) * 14'(ex) + 14'(bz) * 14'(exy);

  assign out_of_range = ({1'b0, bx} >= ex) || ({1'b0, by} >= ey) || ({1'b0, bz} >= ez) ||
                        (32'(idx_full) >= 32'(MAX_MAP_BRICKS));

  assign busy = q_stat.full || init_busy;
  assign push = start && !busy;

  always_comb begin
    item.idx   = idx_full[sbvs_pkg::IDX_W-1:0];
    item.vox   = {pos_z[2:0], pos_y[2:0], pos_x[2:0]};
    item.value = write_value;
    case (cmd)
      sbvs_pkg::CMD_READ:  item.kind = out_of_range ? sbvs_pkg::K_RANGE : sbvs_pkg::K_READ;
      sbvs_pkg::CMD_WRITE: item.kind = out_of_range ? sbvs_pkg::K_RANGE : sbvs_pkg::K_WRITE;
      sbvs_pkg::CMD_CLEAR: item.kind = sbvs_pkg::K_CLEAR;
      default:             item.kind = sbvs_pkg::K_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/sbvs_queue.sv
// ----------------------------------------------------------------------------
// sbvs_queue
// Short item queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module sbvs_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sbvs_pkg::item_t      item_in,
  input  logic                 pop,
  output sbvs_pkg::item_t      item_out,
  output sbvs_pkg::q_status_t  q_stat
);

  localparam int Q_AW = (sbvs_pkg::Q_DEPTH > 1) ? $clog2(sbvs_pkg::Q_DEPTH) : 1;
  localparam int Q_CW = $clog2(sbvs_pkg::Q_DEPTH + 1);

  sbvs_pkg::item_t slots [sbvs_pkg::Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign q_stat.full  = (count == Q_CW'(sbvs_pkg::Q_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign item_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_AW'(sbvs_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(sbvs_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + Q_CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - Q_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/sbvs_back.sv
// ----------------------------------------------------------------------------
// sbvs_back
// Brick map, owner table, voxel pool and the sequencer that executes items.
// ----------------------------------------------------------------------------
`default_nettype none

module sbvs_back #(
  parameter int MAX_MAP_BRICKS = sbvs_pkg::MAX_MAP_BRICKS_DEF,
  parameter int POOL_BRICKS    = sbvs_pkg::POOL_BRICKS_DEF,
  parameter int VOXEL_BITS     = sbvs_pkg::VOXEL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sbvs_pkg::item_t      q_item,
  input  sbvs_pkg::q_status_t  q_stat,
  output logic                 pop,
  output logic                 init_busy,
  output logic                 done,
  output logic [7:0]           read_value,
  output logic [1:0]           status,
  output logic [8:0]           bricks_in_use
);

  localparam int MAP_AW     = (MAX_MAP_BRICKS > 1) ? $clog2(MAX_MAP_BRICKS) : 1;
  localparam int SLOT_W     = (POOL_BRICKS > 1) ? $clog2(POOL_BRICKS) : 1;
  localparam int NF_W       = $clog2(POOL_BRICKS + 1);
  localparam int BB         = sbvs_pkg::BRICK_BITS;
  localparam int POOL_AW    = SLOT_W + BB;
  localparam int POOL_DEPTH = POOL_BRICKS * sbvs_pkg::BRICK_VOXELS;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_MAP,
    B_OWN,
    B_READ,
    B_FILL
  } state_t;

  logic [SLOT_W-1:0]     map_mem   [MAX_MAP_BRICKS];
  logic [MAP_AW-1:0]     owner_mem [POOL_BRICKS];
  logic [VOXEL_BITS-1:0] pool_mem  [POOL_DEPTH];

  state_t                state;
  sbvs_pkg::item_t       cur;
  logic [SLOT_W-1:0]     slot;
  logic [BB-1:0]         fill_cnt;
  logic [MAP_AW-1:0]     init_cnt;
  logic [NF_W-1:0]       next_free;

  logic [SLOT_W-1:0]     map_q;
  logic [MAP_AW-1:0]     own_q;
  logic [VOXEL_BITS-1:0] pool_q;

  logic                  map_we;
  logic [MAP_AW-1:0]     map_wa;
  logic [SLOT_W-1:0]     map_wd;
  logic [MAP_AW-1:0]     map_ra;
  logic                  pool_we;
  logic [POOL_AW-1:0]    pool_a;
  logic [VOXEL_BITS-1:0] pool_wd;

  logic [VOXEL_BITS-1:0] wv;
  logic                  hit;
  logic                  full;
  logic                  alloc;
  logic                  write_hit;
  logic                  fill_last;

  assign wv        = VOXEL_BITS'(cur.value);
  assign hit       = (NF_W'(slot) < next_free) && (own_q == MAP_AW'(cur.idx));
  assign full      = (next_free >= NF_W'(POOL_BRICKS));
  assign write_hit = (state == B_OWN) && (cur.kind == sbvs_pkg::K_WRITE) && hit;
  assign alloc     = (state == B_OWN) && (cur.kind == sbvs_pkg::K_WRITE) && !hit &&
                     (wv != '0) && !full;
  assign fill_last = (fill_cnt == BB'(sbvs_pkg::BRICK_VOXELS - 1));
  assign pop       = (state == B_IDLE) && !q_stat.empty;
  assign init_busy = (state == B_INIT);

  assign map_ra  = MAP_AW'(q_item.idx);
  assign map_we  = init_busy || alloc;
  assign map_wa  = init_busy ? init_cnt : MAP_AW'(cur.idx);
  assign map_wd  = init_busy ? '0 : SLOT_W'(next_free);

  assign pool_we = write_hit || (state == B_FILL);
  assign pool_a  = (state == B_FILL) ? {slot, fill_cnt} : {slot, cur.vox};
  assign pool_wd = ((state == B_FILL) && (fill_cnt != cur.vox)) ? '0 : wv;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (alloc) begin
      owner_mem[SLOT_W'(next_free)] <= MAP_AW'(cur.idx);
    end
    own_q <= owner_mem[map_q];
  end

  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_a] <= pool_wd;
    end else begin
      pool_q <= pool_mem[pool_a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      init_cnt  <= '0;
      next_free <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        B_INIT: begin
          init_cnt <= init_cnt + MAP_AW'(1);
          if (init_cnt == MAP_AW'(MAX_MAP_BRICKS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_stat.empty) begin
            cur <= q_item;
            case (q_item.kind)
              sbvs_pkg::K_READ, sbvs_pkg::K_WRITE: begin
                state <= B_MAP;
              end
              sbvs_pkg::K_CLEAR: begin
                next_free     <= '0;
                done          <= 1'b1;
                read_value    <= '0;
                status        <= sbvs_pkg::ST_OK;
                bricks_in_use <= '0;
              end
              sbvs_pkg::K_RANGE: begin
                done          <= 1'b1;
                read_value    <= '0;
                status        <= sbvs_pkg::ST_RANGE;
                bricks_in_use <= 9'(next_free);
              end
              default: begin
                done          <= 1'b1;
                read_value    <= '0;
                status        <= sbvs_pkg::ST_OK;
                bricks_in_use <= 9'(next_free);
              end
            endcase
          end
        end
        B_MAP: begin
          slot  <= map_q;
          state <= B_OWN;
        end
        B_OWN: begin
          if (cur.kind == sbvs_pkg::K_READ && hit) begin
            state <= B_READ;
          end else if (alloc) begin
            slot     <= SLOT_W'(next_free);
            fill_cnt <= '0;
            state    <= B_FILL;
          end else begin
            done          <= 1'b1;
            read_value    <= '0;
            status        <= (cur.kind == sbvs_pkg::K_WRITE && !hit && wv != '0) ?
                             sbvs_pkg::ST_FULL : sbvs_pkg::ST_OK;
            bricks_in_use <= 9'(next_free);
            state         <= B_IDLE;
          end
        end
        B_READ: begin
          done          <= 1'b1;
          read_value    <= 8'(pool_q);
          status        <= sbvs_pkg::ST_OK;
          bricks_in_use <= 9'(next_free);
          state         <= B_IDLE;
        end
        B_FILL: begin
          fill_cnt <= fill_cnt + BB'(1);
          if (fill_last) begin
            next_free     <= next_free + NF_W'(1);
            done          <= 1'b1;
            read_value    <= '0;
            status        <= sbvs_pkg::ST_OK;
            bricks_in_use <= 9'(next_free + NF_W'(1));
            state         <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/sparse_brick_voxel_store.sv
// ----------------------------------------------------------------------------
// sparse_brick_voxel_store
// Sparse 8x8x8 brickmap voxel store with bump-allocated brick pool.
//
//   channel   handshake              payload
//   command   start / busy           cmd, pos_x, pos_y, pos_z, write_value
//   result    done (one cycle)       read_value, status, bricks_in_use
//   config    cfg_we                 cfg_index, cfg_data
//
// After reset every brick map entry is cleared, with busy high.
// Back part per item: clear, no-op and out of range finish from idle; a read
// hit steps through map read, owner read and pool read; other reads and writes
// via map and owner read; an allocating write then zero fills its new brick.
// The two-item queue lets commands be taken while the back part works.
// Results cannot be stalled; busy is high while the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_brick_voxel_store_macros.svh"

module sparse_brick_voxel_store #(
  parameter int MAX_MAP_BRICKS = sbvs_pkg::MAX_MAP_BRICKS_DEF,
  parameter int POOL_BRICKS    = sbvs_pkg::POOL_BRICKS_DEF,
  parameter int VOXEL_BITS     = sbvs_pkg::VOXEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [6:0]  pos_x,
  input  logic [6:0]  pos_y,
  input  logic [6:0]  pos_z,
  input  logic [7:0]  write_value,
  output logic        done,
  output logic [7:0]  read_value,
  output logic [1:0]  status,
  output logic [8:0]  bricks_in_use
);

  sbvs_pkg::item_t     front_item;
  sbvs_pkg::item_t     q_item;
  sbvs_pkg::q_status_t q_stat;
  logic                push;
  logic                pop;
  logic                init_busy;

  sbvs_front #(
    .MAX_MAP_BRICKS(MAX_MAP_BRICKS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start       (start),
    .cmd         (cmd),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .write_value (write_value),
    .q_stat      (q_stat),
    .init_busy   (init_busy),
    .busy        (busy),
    .push        (push),
    .item        (front_item)
  );

  sbvs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (front_item),
    .pop      (pop),
    .item_out (q_item),
    .q_stat   (q_stat)
  );

  sbvs_back #(
    .MAX_MAP_BRICKS(MAX_MAP_BRICKS),
    .POOL_BRICKS   (POOL_BRICKS),
    .VOXEL_BITS    (VOXEL_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_item        (q_item),
    .q_stat        (q_stat),
    .pop           (pop),
    .init_busy     (init_busy),
    .done          (done),
    .read_value    (read_value),
    .status        (status),
    .bricks_in_use (bricks_in_use)
  );

  `SBVS_ASSERT_ALWAYS(a_no_result_in_init, !(init_busy && done))
  `SBVS_ASSERT_IMP(a_error_reads_zero, done && (status != sbvs_pkg::ST_OK), read_value == 8'd0)
  `SBVS_ASSERT_IMP(a_full_at_pool_size, done && (status == sbvs_pkg::ST_FULL),
                   bricks_in_use == 9'(POOL_BRICKS))

endmodule

`default_nettype wire
